// ===== design/tcrt_pkg.sv =====
// shared types and constants for the thread cancel record table
// no dependencies; imported by the top level, datapath and controller modules
package tcrt_pkg;

  // default sizes, handed to the top level parameters
  localparam int TCRT_RECORDS     = 256;
  localparam int TCRT_ID_WIDTH    = 32;
  localparam int TCRT_VALUE_WIDTH = 32;

  // command codes
  typedef enum logic [2:0] {
    CMD_REGISTER  = 3'd0,
    CMD_DETACH    = 3'd1,
    CMD_EXIT      = 3'd2,
    CMD_TAKE_EXIT = 3'd3,
    CMD_SET_STATE = 3'd4,
    CMD_SET_TYPE  = 3'd5,
    CMD_CANCEL    = 3'd6,
    CMD_TEST      = 3'd7
  } cmd_t;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTHREAD = 3'd3;
  localparam logic [2:0] ST_NOTSUP   = 3'd4;

  // mode argument codes
  localparam logic [1:0] MODE_ENABLE   = 2'd0;
  localparam logic [1:0] MODE_DISABLE  = 2'd1;
  localparam logic [1:0] MODE_DEFERRED = 2'd0;

  // flag bit positions in a packed record, exit value and id sit above them
  localparam int P_DET   = 0;
  localparam int P_ACT   = 1;
  localparam int P_DIS   = 2;
  localparam int P_PEND  = 3;
  localparam int P_FLAGS = 4;

  // controller to datapath commands
  typedef struct packed {
    logic clr_en;
    logic load;
    logic scan_en;
    logic finish;
  } tcrt_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic scan_done;
  } tcrt_sts_t;

endpackage

// ===== design/thread_cancel_record_table_unit.sv =====
// thread cancel record table: one command per transfer, one result per command
// the result follows the scan of the record ram (one read per cycle, stopping at the
// first match) and is held back while the previous result still waits for its transfer
// a new command is taken while the previous result still waits for its transfer
// reset: a clearing sweep zeroes the ram before any input
// depends on tcrt_pkg, tcrt_controller, tcrt_datapath
module thread_cancel_record_table_unit import tcrt_pkg::*; #(
  parameter int RECORDS     = TCRT_RECORDS,
  parameter int ID_WIDTH    = TCRT_ID_WIDTH,
  parameter int VALUE_WIDTH = TCRT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             command,
  input  logic [ID_WIDTH-1:0]    thread_id,
  input  logic [VALUE_WIDTH-1:0] exit_value_in,
  input  logic [1:0]             mode_arg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             status,
  output logic                   old_setting,
  output logic [VALUE_WIDTH-1:0] exit_value_out,
  output logic                   cancel_now
);

  tcrt_ctl_t ctl;
  tcrt_sts_t sts;

  // sequencing
  tcrt_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // record store and decisions
  tcrt_datapath #(
    .RECORDS     (RECORDS),
    .ID_WIDTH    (ID_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .command        (command),
    .thread_id      (thread_id),
    .exit_value_in  (exit_value_in),
    .mode_arg       (mode_arg),
    .status         (status),
    .old_setting    (old_setting),
    .exit_value_out (exit_value_out),
    .cancel_now     (cancel_now)
  );

endmodule

// ===== design/tcrt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module tcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tcrt_datapath.sv =====
// record store, scan unit and command decision logic of the record table
// depends on tcrt_pkg and tcrt_ram
module tcrt_datapath import tcrt_pkg::*; #(
  parameter int RECORDS     = TCRT_RECORDS,
  parameter int ID_WIDTH    = TCRT_ID_WIDTH,
  parameter int VALUE_WIDTH = TCRT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tcrt_ctl_t              ctl,
  output tcrt_sts_t              sts,
  input  logic [2:0]             command,
  input  logic [ID_WIDTH-1:0]    thread_id,
  input  logic [VALUE_WIDTH-1:0] exit_value_in,
  input  logic [1:0]             mode_arg,
  output logic [2:0]             status,
  output logic                   old_setting,
  output logic [VALUE_WIDTH-1:0] exit_value_out,
  output logic                   cancel_now
);

  localparam int AW    = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CW    = $clog2(RECORDS + 1);
  localparam int RW    = ID_WIDTH + VALUE_WIDTH + P_FLAGS;
  localparam int P_VAL = P_FLAGS;
  localparam int P_ID  = P_FLAGS + VALUE_WIDTH;

  // captured command
  cmd_t                   cmd_q;
  logic [ID_WIDTH-1:0]    id_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [1:0]             mode_q;

  // scan state
  logic [CW-1:0] scan_addr;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic [RW-1:0] hit_rec;
  logic          free_found;
  logic [AW-1:0] free_idx;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  // decision results
  logic [2:0]             st_c;
  logic                   old_c;
  logic [VALUE_WIDTH-1:0] xout_c;
  logic                   now_c;
  logic                   wr_need;
  logic [RW-1:0]          wr_rec;
  logic [RW-1:0]          rec_base;
  logic [RW-1:0]          init_rec;
  logic [AW-1:0]          target;
  logic                   id_nz;
  logic                   reg_ok;
  logic                   reg_init;
  logic                   rd_match;
  logic                   issue;

  assign id_nz    = (id_q != '0);
  assign issue    = ctl.scan_en && (scan_addr < CW'(RECORDS));
  assign rd_match = rd_valid && id_nz && (ram_rdata[P_ID +: ID_WIDTH] == id_q);

  assign sts.clr_last  = (scan_addr == CW'(RECORDS - 1));
  assign sts.scan_done = hit_found || ((scan_addr == CW'(RECORDS)) && !rd_valid);

  // capture item and run the scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.load) begin
      cmd_q      <= cmd_t'(command);
      id_q       <= thread_id;
      val_q      <= exit_value_in;
      mode_q     <= mode_arg;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (ctl.clr_en || issue) begin
        scan_addr <= scan_addr + CW'(1);
      end
      rd_valid <= issue;
      rd_idx   <= scan_addr[AW-1:0];
      // first matching record
      if (rd_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_rec   <= ram_rdata;
      end
      // lowest free slot
      if (rd_valid && (ram_rdata[P_ID +: ID_WIDTH] == '0) && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
  end

  // per-command decision
  always_comb begin
    rec_base = hit_found ? hit_rec : '0;
    init_rec = '0;
    init_rec[P_ID +: ID_WIDTH] = id_q;
    init_rec[P_ACT] = 1'b1;
    reg_init = !hit_found || !hit_rec[P_ACT];
    reg_ok   = id_nz && (hit_found || free_found);
    target   = hit_found ? hit_idx : free_idx;
    st_c     = ST_OK;
    old_c    = 1'b0;
    xout_c   = '0;
    now_c    = 1'b0;
    wr_need  = 1'b0;
    wr_rec   = rec_base;
    unique case (cmd_q)
      CMD_REGISTER: begin
        if (!id_nz) begin
          st_c = ST_INVALID;
        end else if (!reg_ok) begin
          st_c = ST_FULL;
        end else if (reg_init) begin
          wr_need = 1'b1;
          wr_rec  = init_rec;
        end
      end
      CMD_DETACH: begin
        if (hit_found) begin
          wr_need        = 1'b1;
          wr_rec[P_DET]  = 1'b1;
          if (!rec_base[P_ACT]) begin
            wr_rec[P_ID +: ID_WIDTH]     = '0;
            wr_rec[P_PEND]               = 1'b0;
            wr_rec[P_VAL +: VALUE_WIDTH] = '0;
          end
        end
      end
      CMD_EXIT: begin
        if (hit_found) begin
          wr_need                      = 1'b1;
          wr_rec[P_ACT]                = 1'b0;
          wr_rec[P_PEND]               = 1'b0;
          wr_rec[P_VAL +: VALUE_WIDTH] = val_q;
          if (rec_base[P_DET]) begin
            wr_rec[P_ID +: ID_WIDTH]     = '0;
            wr_rec[P_VAL +: VALUE_WIDTH] = '0;
          end
        end
      end
      CMD_TAKE_EXIT: begin
        if (hit_found) begin
          xout_c                       = rec_base[P_VAL +: VALUE_WIDTH];
          wr_need                      = 1'b1;
          wr_rec[P_ID +: ID_WIDTH]     = '0;
          wr_rec[P_PEND]               = 1'b0;
          wr_rec[P_VAL +: VALUE_WIDTH] = '0;
          wr_rec[P_ACT]                = 1'b0;
          wr_rec[P_DET]                = 1'b0;
        end
      end
      CMD_SET_STATE: begin
        if ((mode_q != MODE_ENABLE) && (mode_q != MODE_DISABLE)) begin
          st_c = ST_INVALID;
        end else if (!reg_ok) begin
          st_c = ST_FULL;
        end else begin
          if (reg_init) begin
            wr_rec = init_rec;
          end
          old_c         = wr_rec[P_DIS];
          wr_rec[P_DIS] = (mode_q == MODE_DISABLE);
          wr_need       = 1'b1;
        end
      end
      CMD_SET_TYPE: begin
        if (mode_q != MODE_DEFERRED) begin
          st_c = ST_NOTSUP;
        end else if (!reg_ok) begin
          st_c = ST_FULL;
        end else if (reg_init) begin
          wr_need = 1'b1;
          wr_rec  = init_rec;
        end
      end
      CMD_CANCEL: begin
        if (!hit_found || !rec_base[P_ACT]) begin
          st_c = ST_NOTHREAD;
        end else begin
          wr_need        = 1'b1;
          wr_rec[P_PEND] = 1'b1;
        end
      end
      CMD_TEST: begin
        if (hit_found && rec_base[P_ACT] && !rec_base[P_DIS] && rec_base[P_PEND]) begin
          wr_need        = 1'b1;
          wr_rec[P_PEND] = 1'b0;
          now_c          = 1'b1;
        end
      end
      default: begin
        st_c = ST_OK;
      end
    endcase
  end

  // write port: clearing sweep or write-back
  assign ram_we    = ctl.clr_en || (ctl.finish && wr_need);
  assign ram_waddr = ctl.clr_en ? scan_addr[AW-1:0] : target;
  assign ram_wdata = ctl.clr_en ? '0 : wr_rec;

  tcrt_ram #(
    .WIDTH (RW),
    .DEPTH (RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status         <= st_c;
      old_setting    <= old_c;
      exit_value_out <= xout_c;
      cancel_now     <= now_c;
    end
  end

endmodule

// ===== design/tcrt_controller.sv =====
// sequencing state machine of the record table: clear sweep, scan, write-back
// depends on tcrt_pkg
module tcrt_controller import tcrt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tcrt_ctl_t ctl,
  input  tcrt_sts_t sts
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // commands to the datapath
  always_comb begin
    ctl = '0;
    unique case (state)
      S_CLEAR:  ctl.clr_en  = 1'b1;
      S_IDLE:   ctl.load    = in_valid;
      S_SCAN:   ctl.scan_en = 1'b1;
      S_FINISH: ctl.finish  = out_free;
      default:  ctl = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
